@@ hdl/mfblf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfblf_pkg
// Shared types and constants for the monochrome framebuffer with row flush.
// ----------------------------------------------------------------------------
package mfblf_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int ROW_BYTES    = PANEL_WIDTH / 8;
  localparam int HALF_ROWS    = PANEL_HEIGHT / 2;
  localparam int ROW_W        = $clog2(PANEL_HEIGHT);
  localparam int COL_W        = $clog2(PANEL_WIDTH);
  localparam int BYTE_IDX_W   = $clog2(ROW_BYTES);
  localparam int HALF_W       = $clog2(HALF_ROWS);

  localparam logic [7:0] ADDR_CMD     = 8'h80;
  localparam logic [7:0] LOWER_HALF_X = 8'h08;

  // operation codes
  localparam logic [1:0] OP_PIXEL  = 2'd0;
  localparam logic [1:0] OP_FLUSH  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // pixel colors
  localparam logic [1:0] COLOR_CLEAR  = 2'd0;
  localparam logic [1:0] COLOR_SET    = 2'd1;
  localparam logic [1:0] COLOR_INVERT = 2'd2;
  localparam logic [1:0] COLOR_KEEP   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CMD_Y,
    ST_CMD_X,
    ST_DATA
  } state_e;

  typedef enum logic [1:0] {
    SEL_CMD_Y,
    SEL_CMD_X,
    SEL_DATA
  } sel_e;

  typedef struct packed {
    logic accept;     // request taken this cycle, read row
    logic clear_all;  // drop every row
    logic mem_write;  // write modified row back
    logic push;       // load output register
    sel_e sel;        // what the output register gets
    logic cnt_clr;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic pix_ok;     // pixel in bounds and color changes something
    logic out_free;   // output register can take a byte
    logic last_byte;  // byte counter on final byte of row
  } status_t;

endpackage

@@ hdl/mfblf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfblf_ctrl
// Sequencer for pixel read-modify-write, clear and row flush.
// ----------------------------------------------------------------------------
module mfblf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        operation_i,
  input  mfblf_pkg::status_t status_i,
  output mfblf_pkg::cmd_t    cmd_o,
  output logic              in_stall_o
);
  import mfblf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OP_PIXEL && status_i.pix_ok) begin
            state_d = ST_WRITE;
          end else if (operation_i == OP_FLUSH) begin
            state_d = ST_CMD_Y;
          end
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_CMD_Y: begin
        if (status_i.out_free) state_d = ST_CMD_X;
      end
      ST_CMD_X: begin
        if (status_i.out_free) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (status_i.out_free && status_i.last_byte) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_DATA;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.accept    = in_valid_i;
        cmd_o.clear_all = in_valid_i && (operation_i == OP_CLEAR);
      end
      ST_WRITE: cmd_o.mem_write = 1'b1;
      ST_CMD_Y: begin
        cmd_o.push    = status_i.out_free;
        cmd_o.sel     = SEL_CMD_Y;
        cmd_o.cnt_clr = 1'b1;
      end
      ST_CMD_X: begin
        cmd_o.push = status_i.out_free;
        cmd_o.sel  = SEL_CMD_X;
      end
      ST_DATA: begin
        cmd_o.push    = status_i.out_free;
        cmd_o.sel     = SEL_DATA;
        cmd_o.cnt_inc = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

@@ hdl/mfblf_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfblf_dpath
// Row-wide image memory with row valid bits, pixel update and output register.
// ----------------------------------------------------------------------------
module mfblf_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfblf_pkg::cmd_t      cmd_i,
  output mfblf_pkg::status_t   status_o,
  input  logic [1:0]          operation_i,
  input  logic signed [15:0]  pixel_x_i,
  input  logic signed [15:0]  pixel_y_i,
  input  logic [1:0]          color_i,
  input  logic [5:0]          flush_row_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_data_o,
  output logic [7:0]          bus_byte_o,
  output logic                last_o
);
  import mfblf_pkg::*;

  // one word per pixel row, leftmost pixel in the top bit
  logic [PANEL_WIDTH-1:0]  mem [PANEL_HEIGHT];
  logic [PANEL_HEIGHT-1:0] row_valid_q;

  logic [PANEL_WIDTH-1:0]  rd_data_q;
  logic                    rd_valid_q;
  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        col_q;
  logic [1:0]              color_q;
  logic [BYTE_IDX_W-1:0]   cnt_q;

  logic                    out_valid_q;
  logic                    is_data_q, last_q;
  logic [7:0]              byte_q;

  logic [ROW_W-1:0]        rd_addr;
  logic [PANEL_WIDTH-1:0]  row_word, new_word;
  logic [COL_W-1:0]        bit_idx;
  logic                    x_ok, y_ok;

  assign x_ok = (pixel_x_i[15:COL_W] == '0);
  assign y_ok = (pixel_y_i[15:ROW_W] == '0);

  assign rd_addr = (operation_i == OP_FLUSH) ? flush_row_i[ROW_W-1:0]
                                             : pixel_y_i[ROW_W-1:0];

  assign row_word = rd_valid_q ? rd_data_q : '0;
  assign bit_idx  = ~col_q;

  always_comb begin
    new_word = row_word;
    case (color_q)
      COLOR_CLEAR:  new_word[bit_idx] = 1'b0;
      COLOR_SET:    new_word[bit_idx] = 1'b1;
      COLOR_INVERT: new_word[bit_idx] = ~row_word[bit_idx];
      default:      new_word = row_word;
    endcase
  end

  // memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      mem[row_q] <= new_word;
    end
    if (cmd_i.accept) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_all) begin
        row_valid_q <= '0;
      end else if (cmd_i.mem_write) begin
        row_valid_q[row_q] <= 1'b1;
      end
      if (cmd_i.accept) begin
        rd_valid_q <= row_valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_q   <= rd_addr;
      col_q   <= pixel_x_i[COL_W-1:0];
      color_q <= color_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // output register
  logic [7:0] push_byte;
  logic       push_is_data, push_last;

  always_comb begin
    push_byte    = row_word[{~cnt_q, 3'b000} +: 8];
    push_is_data = 1'b1;
    push_last    = (cnt_q == BYTE_IDX_W'(ROW_BYTES - 1));
    case (cmd_i.sel)
      SEL_CMD_Y: begin
        push_byte    = ADDR_CMD | 8'(row_q[HALF_W-1:0]);
        push_is_data = 1'b0;
        push_last    = 1'b0;
      end
      SEL_CMD_X: begin
        push_byte    = row_q[ROW_W-1] ? (ADDR_CMD | LOWER_HALF_X) : ADDR_CMD;
        push_is_data = 1'b0;
        push_last    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      byte_q    <= push_byte;
      is_data_q <= push_is_data;
      last_q    <= push_last;
    end
  end

  assign status_o.pix_ok    = x_ok && y_ok && (color_i != COLOR_KEEP);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.last_byte = (cnt_q == BYTE_IDX_W'(ROW_BYTES - 1));

  assign out_valid_o = out_valid_q;
  assign is_data_o   = is_data_q;
  assign bus_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule

@@ hdl/mono_framebuffer_line_flush_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_line_flush_top
// 128x64 one-bit framebuffer: pixel write, clear, and row flush to a
// graphic-RAM display controller as address commands plus 16 data bytes.
// ----------------------------------------------------------------------------
// Pixel write: row read at accept, then modify and write back in ST_WRITE
//   through the memory write port; out-of-range or no-change pixels skip ST_WRITE.
//   Clear and ignored operations are taken in the idle state alone.
// Flush: the y and x address commands and the 16 data bytes go out at one
//   per cycle through the output register while the display side does not
//   stall; a stalled pending byte holds the flow until it is taken.
// Reset clears every row valid bit at once, so the image reads as all zeros
//   right after reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module mono_framebuffer_line_flush_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] pixel_x_i,
  input  logic signed [15:0] pixel_y_i,
  input  logic [1:0]         color_i,
  input  logic [5:0]         flush_row_i,
  // byte channel to the display
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               is_data_o,
  output logic [7:0]         bus_byte_o,
  output logic               last_o
);
  import mfblf_pkg::*;

  // The image is held as 64 words of 128 bits, one word per pixel row.
  // A row valid bit marks rows written since the last clear; a row that is
  // not valid reads as zeros, which makes both reset and the clear request
  // take effect without a pass over the memory.
  //
  // The controller only takes a request while idle. A pixel write reads its
  // row at accept and writes the modified word back in the next cycle. A
  // flush reads its row at accept, then pushes the y and x address commands
  // and the sixteen data bytes into the output register, waiting whenever
  // the display side stalls. The output register lets the controller accept
  // the next request while the last byte of a flush is still pending.

  cmd_t    cmd;
  status_t status;

  mfblf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  mfblf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .operation_i (operation_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .color_i     (color_i),
    .flush_row_i (flush_row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_data_o   (is_data_o),
    .bus_byte_o  (bus_byte_o),
    .last_o      (last_o)
  );

endmodule
